### hdl/rc5d_pkg.sv
// Shared constants, types and codes for the symbol frame decoder.
package rc5d_pkg;

    localparam int FRAME_BITS = 14;
    localparam int CNT_W      = 4;
    localparam int UNIT_W     = 15;
    localparam int PCT_W      = 7;
    localparam int PROD_W     = UNIT_W + PCT_W;
    localparam int ADDR_W     = 5;
    localparam int CMD_W      = 6;

    localparam logic [UNIT_W-1:0] RESET_UNIT_TIME = 15'd889;
    localparam logic [PCT_W-1:0]  RESET_TOL_PCT   = 7'd25;
    localparam logic [PROD_W-1:0] RESET_PRODUCT   = PROD_W'(889 * 25);

    localparam logic [CNT_W-1:0]  FRAME_COUNT     = CNT_W'(FRAME_BITS);

    // Configuration register indexes.
    localparam logic CFG_UNIT_TIME = 1'b0;
    localparam logic CFG_TOL_PCT   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] raw_code;
        logic                  start_ok;
        logic [CMD_W-1:0]      command_code;
        logic [ADDR_W-1:0]     device_address;
        logic                  toggle;
        status_t               status;
    } result_t;

endpackage

### hdl/rc5_symbol_frame_decoder_top.sv
// Top level of the symbol frame decoder: input register, decode logic, result register.
// Path: a frame-end symbol passes the input register, then the result register, before its
// result shows; while the result register is full it waits in the input register.
// Throughput: one symbol request per cycle; the pace is set by the single input register
// stage, which frees whenever the result register can take a result or none is due.
// Reset: rst_n clears the frame state, both valids, unit_time to 889 and percent to 25.
module rc5_symbol_frame_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [rc5d_pkg::UNIT_W-1:0] cfg_data,
    // Symbol stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // first_level, first_duration, second_duration, zero pad
    input  logic                        s_tlast,   // frame_end
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata    // status, toggle, device_address,
                                                   // command_code, start_ok, raw_code, zero pad
);
    import rc5d_pkg::*;

    // Configuration: unit time and its tolerance product, ready right after a write.
    logic [UNIT_W-1:0] unit_time;
    logic [PROD_W-1:0] tol_product;

    rc5d_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .unit_time   (unit_time),
        .tol_product (tol_product)
    );

    // Input register stage.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              level_reg;
    logic [UNIT_W-1:0] dur0_reg;
    logic [UNIT_W-1:0] dur1_reg;
    logic              last_reg;

    // Result register stage.
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;

    logic              s_take;
    logic              consume;
    logic              good0;
    logic              good1;
    result_t           result;

    // A symbol in the input register leaves when it makes no result, or when the
    // result register is empty or being drained this cycle.
    assign consume  = in_valid_reg & (~last_reg | ~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | consume;
    assign s_take   = s_tvalid & s_tready;

    rc5d_window u_win0 (
        .duration    (dur0_reg),
        .unit_time   (unit_time),
        .tol_product (tol_product),
        .in_window   (good0)
    );

    rc5d_window u_win1 (
        .duration    (dur1_reg),
        .unit_time   (unit_time),
        .tol_product (tol_product),
        .in_window   (good1)
    );

    rc5d_frame u_frame (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (consume),
        .level    (level_reg),
        .last     (last_reg),
        .sym_good (good0 & good1),
        .result   (result)
    );

    always_comb
    begin
        // Hold the input register until its symbol is consumed.
        if (s_take)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        // Load a result on frame end, drop it once taken.
        if (consume & last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            level_reg <= s_tdata[0];
            dur0_reg  <= s_tdata[UNIT_W:1];
            dur1_reg  <= s_tdata[2*UNIT_W:UNIT_W+1];
            last_reg  <= s_tlast;
        end
        if (consume & last_reg)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

### hdl/rc5d_cfg.sv
// Configuration registers and the registered tolerance product unit_time * percent.
module rc5d_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [rc5d_pkg::UNIT_W-1:0] cfg_data,
    output logic [rc5d_pkg::UNIT_W-1:0] unit_time,
    output logic [rc5d_pkg::PROD_W-1:0] tol_product
);
    import rc5d_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    logic [UNIT_W-1:0] unit_next;
    logic [PCT_W-1:0]  pct_reg;
    logic [PCT_W-1:0]  pct_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        unit_next = unit_reg;
        pct_next  = pct_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT_TIME: unit_next = cfg_data;
                CFG_TOL_PCT:   pct_next  = cfg_data[PCT_W-1:0];
                default:       unit_next = unit_reg;
            endcase
        end
        // Product follows the new values so an item right after a write sees them.
        prod_next = PROD_W'(unit_next) * PROD_W'(pct_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= RESET_UNIT_TIME;
            pct_reg  <= RESET_TOL_PCT;
            prod_reg <= RESET_PRODUCT;
        end
        else
        begin
            unit_reg <= unit_next;
            pct_reg  <= pct_next;
            prod_reg <= prod_next;
        end
    end

    assign unit_time   = unit_reg;
    assign tol_product = prod_reg;

endmodule

### hdl/rc5d_window.sv
// Duration window check: 100 * |d - unit| <= unit * percent.
module rc5d_window (
    input  logic [rc5d_pkg::UNIT_W-1:0] duration,
    input  logic [rc5d_pkg::UNIT_W-1:0] unit_time,
    input  logic [rc5d_pkg::PROD_W-1:0] tol_product,
    output logic                        in_window
);
    import rc5d_pkg::*;

    logic [UNIT_W-1:0] diff;
    logic [PROD_W-1:0] diff_scaled;

    always_comb
    begin
        diff = (duration >= unit_time) ? (duration - unit_time) : (unit_time - duration);
        // times 100 as 64 + 32 + 4
        diff_scaled = (PROD_W'(diff) << 6) + (PROD_W'(diff) << 5) + (PROD_W'(diff) << 2);
        in_window = (diff_scaled <= tol_product);
    end

endmodule

### hdl/rc5d_frame.sv
// Frame state (symbol count, bit shifter, bad flag) and result composition.
module rc5d_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               level,
    input  logic               last,
    input  logic               sym_good,
    output rc5d_pkg::result_t  result
);
    import rc5d_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [FRAME_BITS-1:0] shift_reg;
    logic [FRAME_BITS-1:0] shift_next;
    logic                  bad_reg;
    logic                  bad_next;

    logic [CNT_W-1:0]      upd_count;
    logic [FRAME_BITS-1:0] upd_shift;
    logic                  upd_bad;

    always_comb
    begin
        upd_count = count_reg;
        upd_shift = shift_reg;
        upd_bad   = bad_reg;
        // Symbols past the frame length are dropped untimed.
        if (count_reg < FRAME_COUNT)
        begin
            upd_count = count_reg + CNT_W'(1);
            upd_shift = {shift_reg[FRAME_BITS-2:0], level};
            upd_bad   = bad_reg | ~sym_good;
        end

        result = '0;
        if (upd_count < FRAME_COUNT)
            result.status = STATUS_SHORT;
        else if (upd_bad)
            result.status = STATUS_BAD;
        else
        begin
            result.status         = STATUS_OK;
            result.raw_code       = upd_shift;
            result.toggle         = upd_shift[11];
            result.device_address = upd_shift[10:6];
            result.command_code   = upd_shift[5:0];
            result.start_ok       = &upd_shift[13:12];
        end

        count_next = count_reg;
        shift_next = shift_reg;
        bad_next   = bad_reg;
        if (take)
        begin
            if (last)
            begin
                count_next = '0;
                shift_next = '0;
                bad_next   = 1'b0;
            end
            else
            begin
                count_next = upd_count;
                shift_next = upd_shift;
                bad_next   = upd_bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            shift_reg <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            shift_reg <= shift_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

### tb/sv/tb_rc5_symbol_frame_decoder_top.sv
// Self-checking testbench for the RC5 symbol frame decoder top level.
`timescale 1ns / 100ps

module tb_rc5_symbol_frame_decoder_top;
    import rc5d_pkg::*;

    localparam int DUR_MAX         = 2**UNIT_W - 1;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_REQUESTS  = 60;

    // Results that a glance at the frame rules gives away.
    localparam result_t ONES_OK = '{raw_code: 14'h3FFF, start_ok: 1'b1, command_code: 6'h3F,
                                    device_address: 5'h1F, toggle: 1'b1, status: STATUS_OK};
    localparam result_t SHORT_FAIL = '{raw_code: '0, start_ok: 1'b0, command_code: '0,
                                       device_address: '0, toggle: 1'b0, status: STATUS_SHORT};
    localparam result_t BAD_FAIL = '{raw_code: '0, start_ok: 1'b0, command_code: '0,
                                     device_address: '0, toggle: 1'b0, status: STATUS_BAD};
    localparam result_t NO_RESULT = '0;

    // One row of directed stimulus: the same symbol repeated, frame end on the last copy.
    typedef struct packed {
        int      reps;
        bit      level;
        int      d0;
        int      d1;
        bit      last;
        bit      typed;
        result_t want;
    } sym_row_t;

    // Directed frames, run at the reset window of 889 +/- 222 ticks (667..1111).
    localparam sym_row_t DIRECTED [7] = '{
        // lone symbol with both durations at the extremes: short wins over bad timing
        '{1,  1'b1, 0,    DUR_MAX, 1'b1, 1'b1, SHORT_FAIL},
        // fourteen ones sitting right on the window edges
        '{13, 1'b1, 667,  1111,    1'b0, 1'b0, NO_RESULT},
        '{1,  1'b1, 1111, 667,     1'b1, 1'b1, ONES_OK},
        // first symbol one tick under the window, start bits not both one
        '{1,  1'b0, 666,  889,     1'b0, 1'b0, NO_RESULT},
        '{12, 1'b0, 889,  889,     1'b0, 1'b0, NO_RESULT},
        '{1,  1'b1, 889,  889,     1'b0, 1'b0, NO_RESULT},
        // extra fifteenth symbol, badly timed but ignored; status stays bad
        '{1,  1'b1, 1112, 0,       1'b1, 1'b1, BAD_FAIL}
    };

    // Per phase: window setting (-1 draws a random value), idling, pressure events.
    typedef struct packed {
        int unit;
        int pct;
        int send_idle;
        int recv_stall;
        bit hold_mid;
        bit drain_mid;
    } phase_t;

    localparam phase_t PHASES [8] = '{
        '{889,     25,  0,  0,  1'b1, 1'b0},
        '{1,       0,   80, 0,  1'b0, 1'b0},
        '{DUR_MAX, 100, 0,  80, 1'b0, 1'b0},
        '{0,       50,  22, 22, 1'b0, 1'b0},
        '{DUR_MAX, 127, 0,  0,  1'b0, 1'b1},
        '{-1,      -1,  80, 0,  1'b0, 1'b0},
        '{300,     10,  0,  80, 1'b0, 1'b0},
        '{-1,      -1,  22, 22, 1'b0, 1'b1}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [UNIT_W-1:0] cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;

    // Decoder model state and its copy of the window registers.
    int                    unit_ticks = int'(RESET_UNIT_TIME);
    int                    tol_pct    = int'(RESET_TOL_PCT);
    int                    sym_count  = 0;
    logic [FRAME_BITS-1:0] shift_reg  = '0;
    bit                    bad_flag   = 1'b0;

    result_t predicted_frames [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_go    = 1'b0;
    int hold_left      = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    rc5_symbol_frame_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Allowed deviation is floor(unit * pct / 100); return the lower or upper window edge,
    // clipped to the duration range.
    function automatic int window_edge(bit upper);
        int tol;
        tol = (unit_ticks * tol_pct) / 100;
        if (upper)
            return (unit_ticks + tol > DUR_MAX) ? DUR_MAX : unit_ticks + tol;
        return (unit_ticks > tol) ? unit_ticks - tol : 0;
    endfunction

    function automatic bit in_window(int d);
        int tol;
        int diff;
        tol  = (unit_ticks * tol_pct) / 100;
        diff = (d >= unit_ticks) ? d - unit_ticks : unit_ticks - d;
        return diff <= tol;
    endfunction

    // Advance the frame by one symbol; return 1 with the frame result on frame end.
    function automatic bit decode_symbol(bit level, int d0, int d1, bit last,
                                         output result_t frame);
        frame = '0;
        if (sym_count < FRAME_BITS)
        begin
            if (!(in_window(d0) && in_window(d1)))
                bad_flag = 1'b1;
            shift_reg = {shift_reg[FRAME_BITS-2:0], level};
            sym_count++;
        end
        if (!last)
            return 1'b0;
        if (sym_count < FRAME_BITS)
            frame.status = STATUS_SHORT;
        else if (bad_flag)
            frame.status = STATUS_BAD;
        else
        begin
            frame.status         = STATUS_OK;
            frame.raw_code       = shift_reg;
            frame.toggle         = shift_reg[11];
            frame.device_address = shift_reg[10:6];
            frame.command_code   = shift_reg[5:0];
            frame.start_ok       = &shift_reg[13:12];
        end
        sym_count = 0;
        shift_reg = '0;
        bad_flag  = 1'b0;
        return 1'b1;
    endfunction

    // Durations inside the window, with the edges picked now and then.
    function automatic int good_ticks();
        int lo;
        int hi;
        int pick;
        lo   = window_edge(1'b0);
        hi   = window_edge(1'b1);
        pick = $urandom_range(7, 0);
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    // Durations outside the window; any value when the window spans the whole range.
    function automatic int bad_ticks();
        int lo;
        int hi;
        lo = window_edge(1'b0);
        hi = window_edge(1'b1);
        if (lo == 0 && hi == DUR_MAX)
            return $urandom_range(DUR_MAX, 0);
        if (hi == DUR_MAX || (lo > 0 && $urandom_range(1, 0) == 1))
            return ($urandom_range(1, 0) == 1) ? lo - 1 : $urandom_range(lo - 1, 0);
        return ($urandom_range(1, 0) == 1) ? hi + 1 : $urandom_range(DUR_MAX, hi + 1);
    endfunction

    task automatic write_reg(logic idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[UNIT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_UNIT_TIME)
            unit_ticks = value & DUR_MAX;
        else
            tol_pct = value & (2**PCT_W - 1);
    endtask

    // Offer one symbol request after a random gap, hold it until accepted, then predict.
    task automatic send_symbol(bit level, int d0, int d1, bit last, bit typed,
                               result_t typed_want);
        result_t predicted;
        bit      has_result;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, d1[UNIT_W-1:0], d0[UNIT_W-1:0], level};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        has_result = decode_symbol(level, d0, d1, last, predicted);
        if (has_result)
            predicted_frames.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid, wait for every outstanding result, then let the input stage empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (predicted_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random frames: mostly well-formed with random bits and the odd bad symbol,
    // some short ones, some pure noise. Frames always close with frame end.
    task automatic run_frames(int budget, bit hold_mid, bit drain_mid);
        int sent;
        int len;
        int kind;
        int bad_pos;
        int i;
        int d0;
        int d1;
        bit lvl;
        sent = 0;
        while (sent < budget)
        begin
            if (hold_mid && sent >= budget / 2)
            begin
                hold_off_go = 1'b1;
                hold_mid    = 1'b0;
            end
            if (drain_mid && sent >= budget / 2)
            begin
                wait_drained();
                drain_mid = 1'b0;
            end
            kind = $urandom_range(99, 0);
            if (kind < 60)
                len = FRAME_BITS + (($urandom_range(99, 0) < 20) ? $urandom_range(3, 1) : 0);
            else if (kind < 85)
                len = $urandom_range(FRAME_BITS - 1, 1);
            else
                len = $urandom_range(FRAME_BITS + 4, 1);
            bad_pos = ($urandom_range(99, 0) < 25) ? $urandom_range(len - 1, 0) : -1;
            for (i = 0; i < len; i++)
            begin
                if (kind >= 85)
                begin
                    lvl = 1'($urandom_range(1, 0));
                    d0  = $urandom_range(DUR_MAX, 0);
                    d1  = $urandom_range(DUR_MAX, 0);
                end
                else
                begin
                    // keep the start bits mostly at one so the success path is exercised
                    lvl = (i < 2 && $urandom_range(99, 0) < 80) ? 1'b1
                                                                : 1'($urandom_range(1, 0));
                    d0  = good_ticks();
                    d1  = good_ticks();
                    if (i == bad_pos)
                    begin
                        if ($urandom_range(1, 0) == 1)
                            d0 = bad_ticks();
                        else
                            d1 = bad_ticks();
                    end
                end
                send_symbol(lvl, d0, d1, i == len - 1, 1'b0, NO_RESULT);
                sent++;
            end
        end
    endtask

    task automatic note_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: expected st=%0d tg=%0d addr=%0d cmd=%0d so=%0d raw=%h",
                     what, want.status, want.toggle, want.device_address,
                     want.command_code, want.start_ok, want.raw_code);
            $display("%s: got      st=%0d tg=%0d addr=%0d cmd=%0d so=%0d raw=%h",
                     what, got.status, got.toggle, got.device_address,
                     got.command_code, got.start_ok, got.raw_code);
        end
    endtask

    // Receiver: random stalls, or a long hold-off counted here once requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction, field by field.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (predicted_frames.size() == 0)
                note_mismatch("unexpected result", NO_RESULT, got);
            else
            begin
                want = predicted_frames.pop_front();
                if (got.status !== want.status || got.toggle !== want.toggle
                    || got.device_address !== want.device_address
                    || got.command_code !== want.command_code
                    || got.start_ok !== want.start_ok || got.raw_code !== want.raw_code)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // Main sequence: reset, directed frames, then random phases with new windows.
    initial
    begin
        int r;
        int k;
        int p;
        int spin;
        int unit_sel;
        int pct_sel;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_UNIT_TIME;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset window, no idling.
        for (r = 0; r < $size(DIRECTED); r++)
            for (k = 0; k < DIRECTED[r].reps; k++)
                send_symbol(DIRECTED[r].level, DIRECTED[r].d0, DIRECTED[r].d1,
                            DIRECTED[r].last && k == DIRECTED[r].reps - 1,
                            DIRECTED[r].typed && k == DIRECTED[r].reps - 1,
                            DIRECTED[r].want);

        // Rewrite the window only while nothing is in flight.
        for (p = 0; p < $size(PHASES); p++)
        begin
            wait_drained();
            unit_sel = (PHASES[p].unit < 0) ? $urandom_range(DUR_MAX, 1) : PHASES[p].unit;
            pct_sel  = (PHASES[p].pct < 0) ? $urandom_range(2**PCT_W - 1, 0) : PHASES[p].pct;
            write_reg(CFG_UNIT_TIME, unit_sel);
            write_reg(CFG_TOL_PCT, pct_sel);
            send_idle_pct  = PHASES[p].send_idle;
            recv_stall_pct = PHASES[p].recv_stall;
            run_frames(PHASE_REQUESTS, PHASES[p].hold_mid, PHASES[p].drain_mid);
        end

        // Drain with a bound, let the pipeline settle, then count leftovers.
        s_tvalid <= 1'b0;
        for (spin = 0; spin < 5000 && predicted_frames.size() != 0; spin++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (predicted_frames.size() != 0)
        begin
            $display("%0d predicted results never arrived", predicted_frames.size());
            mismatches += predicted_frames.size();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
